// ===== rtl/cdadd_pkg.sv =====
`timescale 1ns / 1ps

package cdadd_pkg;

  localparam int MAX_YEAR = 9999;
  localparam int MIN_YEAR = 1900;

  // Divider operand widths: dividends stay below 2^16, divisors stay at or below 100.
  localparam int DW    = 17;
  localparam int RW    = 7;
  localparam int QW    = 10;

  // Reciprocals are scaled by 2^RCP_SHIFT and rounded up. The quotient is exact for
  // every dividend below 2^DW.
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = 22;
  localparam int PW        = DW + RCP_W;

  localparam logic [1:0] KIND_DAYS   = 2'd0;
  localparam logic [1:0] KIND_MONTHS = 2'd1;
  localparam logic [1:0] KIND_YEARS  = 2'd2;

  localparam logic [RW-1:0] DIV_CENTURY = RW'(100);
  localparam logic [RW-1:0] DIV_MONTHS  = RW'(12);
  localparam logic [RW-1:0] DIV_WEEK    = RW'(7);

  localparam logic [RCP_W-1:0] RCP_CENTURY = RCP_W'(167773);
  localparam logic [RCP_W-1:0] RCP_MONTHS  = RCP_W'(1398102);
  localparam logic [RCP_W-1:0] RCP_WEEK    = RCP_W'(2396746);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [RW-1:0] CENT_LAST = RW'(99);

  // The weekday sum is lifted by a multiple of seven so that it never goes negative;
  // the extra five is the constant term of the rule.
  localparam int WEEK_BIAS = 7 * ((2 * (MAX_YEAR / 100)) / 7 + 1) + 5;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [RW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quo;
    logic [RW-1:0] rem;
  } div_rsp_t;

  function automatic logic [RCP_W-1:0] recip(input logic [RW-1:0] dvs);
    logic [RCP_W-1:0] v;
    case (dvs)
      DIV_CENTURY: v = RCP_CENTURY;
      DIV_MONTHS:  v = RCP_MONTHS;
      DIV_WEEK:    v = RCP_WEEK;
      default:     v = '0;
    endcase
    return v;
  endfunction

  // The year is given as its quotient and remainder by 100.
  function automatic logic is_leap(input logic [QW-1:0] q, input logic [RW-1:0] r);
    return (r[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
      4'd2:                                    len = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                 len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic signed [DW-1:0] d, input logic [3:0] m,
                                   input logic signed [DW-1:0] y, input logic leap);
    logic [4:0] len;
    len = month_len(m, leap);
    return (y >= MIN_YEAR) && (y <= MAX_YEAR) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
           (d >= 1) && (d <= $signed(DW'(len)));
  endfunction

  // Month term of the weekday rule, (13 * (m + 1)) / 5, with March as 3 and February as 14.
  function automatic logic [5:0] zeller_term(input logic [3:0] mm);
    logic [5:0] v;
    case (mm)
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      4'd13:   v = 6'd36;
      4'd14:   v = 6'd39;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cdadd_div.sv =====
`timescale 1ns / 1ps

module cdadd_div (
  input  logic                clk,
  input  logic                rst,
  input  cdadd_pkg::div_req_t req,
  output cdadd_pkg::div_rsp_t rsp
);

  logic                                busy1;
  logic                                busy2;
  logic                                done;
  logic [cdadd_pkg::DW-1:0]            num;
  logic [cdadd_pkg::RW-1:0]            dvs;
  logic [cdadd_pkg::RCP_W-1:0]         rcp;
  logic [cdadd_pkg::PW-1:0]            prod;
  logic [cdadd_pkg::DW-1:0]            quo_c;
  logic [cdadd_pkg::DW+cdadd_pkg::RW-1:0] back;
  logic [cdadd_pkg::DW-1:0]            left;
  logic [cdadd_pkg::DW-1:0]            quo;
  logic [cdadd_pkg::RW-1:0]            rem;

  assign quo_c = cdadd_pkg::DW'(prod[cdadd_pkg::PW-1:cdadd_pkg::RCP_SHIFT]);
  assign back  = quo_c * dvs;
  assign left  = num - back[cdadd_pkg::DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy1 <= 1'b0;
      busy2 <= 1'b0;
      done  <= 1'b0;
    end else begin
      busy1 <= req.start;
      busy2 <= busy1;
      done  <= busy2;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      dvs <= req.divisor;
      rcp <= cdadd_pkg::recip(req.divisor);
    end
    if (busy1) begin
      prod <= num * rcp;
    end
    if (busy2) begin
      quo <= quo_c;
      rem <= left[cdadd_pkg::RW-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ===== rtl/calendar_date_adder.sv =====
`timescale 1ns / 1ps

// Gregorian date adder. An input word carries a date, an operation kind and a signed
// amount; the output word carries the resulting date, an ok flag and the weekday
// (0 is Monday). A rejected operation returns the original date with ok low.
// Both channels use valid and stall; a word moves when valid is high and stall low.
// The block takes one word at a time: in_stall is high from acceptance until the
// result has been loaded into the output register. The result then waits there
// while a new input word may already be accepted.
// All divisions (by 100, 12 or 7) go through one shared reciprocal-multiply divider,
// which registers its operands, then their product, then the quotient and remainder.
// Day addition steps through the months one boundary at a time, so its time grows
// with the number of month boundaries crossed. With no stall, the next word is
// accepted in the cycle after the result is loaded.
// When the receiver stalls, the result stays in the output register and the block
// finishes at most one more word before it waits for the register to drain.
// Reset returns the sequencer to idle and drops out_valid.
module calendar_date_adder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic signed [15:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  new_day,
  output logic [3:0]  new_month,
  output logic [13:0] new_year,
  output logic        ok,
  output logic [2:0]  weekday
);

  localparam int DW = cdadd_pkg::DW;
  localparam int QW = cdadd_pkg::QW;
  localparam int RW = cdadd_pkg::RW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DIVY0 = 11'b00000000010,
    S_CHECK = 11'b00000000100,
    S_WALK  = 11'b00000001000,
    S_DIVT  = 11'b00000010000,
    S_YCHK  = 11'b00000100000,
    S_DIVY  = 11'b00001000000,
    S_FINAL = 11'b00010000000,
    S_WDAY  = 11'b00100000000,
    S_DIVW  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  cdadd_pkg::div_req_t div_req;
  cdadd_pkg::div_rsp_t div_rsp;

  logic [1:0]              kind_r;
  logic [4:0]              d0;
  logic [3:0]              m0;
  logic [13:0]             y0;
  logic signed [15:0]      amt;
  logic [QW-1:0]           q0;
  logic [RW-1:0]           r0;
  logic signed [DW-1:0]    acc;
  logic [3:0]              wm;
  logic signed [DW-1:0]    wy;
  logic [QW-1:0]           wq;
  logic [RW-1:0]           wr;
  logic                    tneg;
  logic [4:0]              rd;
  logic [3:0]              rm;
  logic [13:0]             ry;
  logic [QW-1:0]           rq;
  logic [RW-1:0]           rr;
  logic                    ok_r;
  logic [2:0]              wd_r;

  logic                    out_free;
  logic                    in_ok;
  logic signed [DW-1:0]    day_sum;
  logic signed [DW-1:0]    y_sum;
  logic signed [DW-1:0]    tval;
  logic [DW-1:0]           t_mag;
  logic                    y_in_range;
  logic                    leap_c;
  logic [4:0]              len_c;
  logic [RW-1:0]           ny_r;
  logic [QW-1:0]           ny_q;
  logic [RW-1:0]           py_r;
  logic [QW-1:0]           py_q;
  logic [3:0]              pm;
  logic [4:0]              plen;
  logic                    walk_step;
  logic                    fin_ok;
  logic                    wk_early;
  logic [3:0]              wk_m;
  logic [RW-1:0]           wk_k;
  logic [QW-1:0]           wk_j;
  logic [DW-1:0]           f_sum;

  cdadd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign in_ok   = cdadd_pkg::date_ok($signed(DW'(d0)), m0, $signed(DW'(y0)),
                                      cdadd_pkg::is_leap(q0, r0));
  assign day_sum = $signed(DW'(d0)) + DW'(amt);
  assign y_sum   = $signed(DW'(y0)) + DW'(amt);
  assign tval    = $signed(DW'(m0)) - DW'(1) + DW'(amt);
  assign t_mag   = tval[DW-1] ? DW'(-tval) : DW'(tval);

  assign y_in_range = (wy >= cdadd_pkg::MIN_YEAR) && (wy <= cdadd_pkg::MAX_YEAR);

  assign leap_c = cdadd_pkg::is_leap(wq, wr);
  assign len_c  = cdadd_pkg::month_len(wm, leap_c);
  assign ny_r   = (wr == cdadd_pkg::CENT_LAST) ? '0 : wr + 1'b1;
  assign ny_q   = (wr == cdadd_pkg::CENT_LAST) ? wq + 1'b1 : wq;
  assign py_r   = (wr == '0) ? cdadd_pkg::CENT_LAST : wr - 1'b1;
  assign py_q   = (wr == '0) ? wq - 1'b1 : wq;
  assign pm     = (wm == cdadd_pkg::MONTH_JAN) ? cdadd_pkg::MONTH_DEC : wm - 1'b1;
  assign plen   = cdadd_pkg::month_len(pm, (wm == cdadd_pkg::MONTH_JAN) ?
                                       cdadd_pkg::is_leap(py_q, py_r) : leap_c);

  assign walk_step = amt[15] ? (acc <= 0) : (acc > $signed(DW'(len_c)));

  assign fin_ok = cdadd_pkg::date_ok(acc, wm, wy, leap_c);

  assign wk_early = (rm < cdadd_pkg::MONTH_MAR);
  assign wk_m     = wk_early ? rm + 4'(cdadd_pkg::MONTH_DEC) : rm;
  assign wk_k     = wk_early ? ((rr == '0) ? cdadd_pkg::CENT_LAST : rr - 1'b1) : rr;
  assign wk_j     = (wk_early && (rr == '0)) ? rq - 1'b1 : rq;
  assign f_sum    = DW'(cdadd_pkg::WEEK_BIAS) + DW'(rd) + DW'(cdadd_pkg::zeller_term(wk_m)) +
                    DW'(wk_k) + DW'(wk_k[RW-1:2]) + DW'(wk_j[QW-1:2]) - DW'({wk_j, 1'b0});

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DW'(y0);
    div_req.divisor  = cdadd_pkg::DIV_CENTURY;
    case (state)
      S_IDLE: begin
        div_req.start    = in_valid;
        div_req.dividend = DW'(year);
      end
      S_CHECK: begin
        div_req.start    = in_ok && (kind_r == cdadd_pkg::KIND_MONTHS);
        div_req.dividend = t_mag;
        div_req.divisor  = cdadd_pkg::DIV_MONTHS;
      end
      S_YCHK: begin
        div_req.start    = y_in_range;
        div_req.dividend = DW'(wy);
      end
      S_WDAY: begin
        div_req.start    = 1'b1;
        div_req.dividend = f_sum;
        div_req.divisor  = cdadd_pkg::DIV_WEEK;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIVY0;
      end
      S_DIVY0: begin
        if (div_rsp.done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!in_ok) begin
          state_next = S_EMIT;
        end else begin
          case (kind_r)
            cdadd_pkg::KIND_DAYS:   state_next = S_WALK;
            cdadd_pkg::KIND_MONTHS: state_next = S_DIVT;
            cdadd_pkg::KIND_YEARS:  state_next = S_YCHK;
            default:                state_next = S_WDAY;
          endcase
        end
      end
      S_WALK: begin
        if (!walk_step) state_next = S_FINAL;
      end
      S_DIVT: begin
        if (div_rsp.done) state_next = S_YCHK;
      end
      S_YCHK: begin
        state_next = y_in_range ? S_DIVY : S_FINAL;
      end
      S_DIVY: begin
        if (div_rsp.done) state_next = S_FINAL;
      end
      S_FINAL: begin
        state_next = S_WDAY;
      end
      S_WDAY: begin
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_r <= kind;
          d0     <= day;
          m0     <= month;
          y0     <= year;
          amt    <= amount;
        end
      end
      S_DIVY0: begin
        if (div_rsp.done) begin
          q0 <= div_rsp.quo[QW-1:0];
          r0 <= div_rsp.rem;
        end
      end
      S_CHECK: begin
        acc  <= (kind_r == cdadd_pkg::KIND_DAYS) ? day_sum : $signed(DW'(d0));
        wm   <= m0;
        wy   <= (kind_r == cdadd_pkg::KIND_YEARS) ? y_sum : $signed(DW'(y0));
        wq   <= q0;
        wr   <= r0;
        tneg <= tval[DW-1];
        rd   <= d0;
        rm   <= m0;
        ry   <= y0;
        rq   <= q0;
        rr   <= r0;
        ok_r <= 1'b0;
        wd_r <= '0;
      end
      S_WALK: begin
        if (walk_step) begin
          if (!amt[15]) begin
            acc <= acc - $signed(DW'(len_c));
            if (wm == cdadd_pkg::MONTH_DEC) begin
              wm <= cdadd_pkg::MONTH_JAN;
              wy <= wy + DW'(1);
              wq <= ny_q;
              wr <= ny_r;
            end else begin
              wm <= wm + 1'b1;
            end
          end else begin
            acc <= acc + $signed(DW'(plen));
            wm  <= pm;
            if (wm == cdadd_pkg::MONTH_JAN) begin
              wy <= wy - DW'(1);
              wq <= py_q;
              wr <= py_r;
            end
          end
        end
      end
      S_DIVT: begin
        if (div_rsp.done) begin
          if (!tneg) begin
            wy <= $signed(DW'(y0)) + $signed(div_rsp.quo);
            wm <= div_rsp.rem[3:0] + 1'b1;
          end else if (div_rsp.rem == '0) begin
            wy <= $signed(DW'(y0)) - $signed(div_rsp.quo);
            wm <= cdadd_pkg::MONTH_JAN;
          end else begin
            wy <= $signed(DW'(y0)) - $signed(div_rsp.quo) - DW'(1);
            wm <= cdadd_pkg::MONTH_DEC + 1'b1 - div_rsp.rem[3:0];
          end
        end
      end
      S_DIVY: begin
        if (div_rsp.done) begin
          wq <= div_rsp.quo[QW-1:0];
          wr <= div_rsp.rem;
        end
      end
      S_FINAL: begin
        if (fin_ok) begin
          rd   <= acc[4:0];
          rm   <= wm;
          ry   <= wy[13:0];
          rq   <= wq;
          rr   <= wr;
          ok_r <= 1'b1;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          wd_r <= div_rsp.rem[2:0];
        end
      end
      S_EMIT: begin
        if (out_free) begin
          new_day   <= rd;
          new_month <= rm;
          new_year  <= ry;
          ok        <= ok_r;
          weekday   <= wd_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_starts_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_DIVY0))
    else $error("accepted word did not start the year split");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVY0 || state == S_DIVT || state == S_DIVY ||
                      state == S_DIVW))
    else $error("divider finished while the sequencer was not waiting for it");

  a_ok_year_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ok) |-> (new_year >= 14'(cdadd_pkg::MIN_YEAR) &&
                           new_year <= 14'(cdadd_pkg::MAX_YEAR)))
    else $error("accepted result has a year outside the valid range");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday <= 3'd6))
    else $error("weekday out of range");

endmodule

// ===== bench/calendar_date_adder_tb.sv =====
`timescale 1ns / 1ps

module calendar_date_adder_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 1200;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  typedef struct {
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic        ok;
    logic [2:0]  wd;
  } date_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [4:0] day = '0;
  logic [3:0] month = '0;
  logic [13:0] year = '0;
  logic signed [15:0] amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] new_day;
  logic [3:0] new_month;
  logic [13:0] new_year;
  logic ok;
  logic [2:0] weekday;

  date_result_t expected_dates[$];
  date_result_t oldest_date;
  int errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  int pattern_count = 0;
  logic hold_start = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;

  calendar_date_adder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .day(day),
    .month(month),
    .year(year),
    .amount(amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_day(new_day),
    .new_month(new_month),
    .new_year(new_year),
    .ok(ok),
    .weekday(weekday)
  );

  always #10 clk = ~clk;

  function automatic logic leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(input int m, input int y);
    int len;
    case (m)
      4, 6, 9, 11:               len = 30;
      2:                         len = leap_year(y) ? 29 : 28;
      1, 3, 5, 7, 8, 10, 12:     len = 31;
      default:                   len = 0;
    endcase
    return len;
  endfunction

  function automatic logic date_in_range(input int d, input int m, input int y);
    if (y < cdadd_pkg::MIN_YEAR || y > cdadd_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1) begin
      return 1'b0;
    end
    return d <= month_days(m, y);
  endfunction

  function automatic int weekday_index(input int d, input int m, input int y);
    int k, j, f;
    if (m < 3) begin
      m = m + 12;
      y = y - 1;
    end
    k = y % 100;
    j = y / 100;
    f = d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 - 2 * j + 5;
    f = f % 7;
    if (f < 0) begin
      f = f + 7;
    end
    return f;
  endfunction

  function automatic date_result_t shift_date(input logic [1:0] k, input logic [4:0] d_in,
                                              input logic [3:0] m_in, input logic [13:0] y_in,
                                              input logic signed [15:0] a_in);
    date_result_t r;
    int d0, m0, y0, amt, d, m, y, acc, t, adj, wd;
    logic good;
    d0 = d_in;
    m0 = m_in;
    y0 = y_in;
    amt = a_in;
    d = d0;
    m = m0;
    y = y0;
    good = 1'b0;
    wd = 0;
    if (date_in_range(d0, m0, y0)) begin
      if (k == cdadd_pkg::KIND_DAYS) begin
        acc = d0 + amt;
        if (amt > 0) begin
          while (acc > month_days(m, y)) begin
            acc = acc - month_days(m, y);
            if (m == 12) begin
              m = 1;
              y = y + 1;
            end else begin
              m = m + 1;
            end
          end
        end else if (amt < 0) begin
          while (acc <= 0) begin
            if (m == 1) begin
              m = 12;
              y = y - 1;
            end else begin
              m = m - 1;
            end
            acc = acc + month_days(m, y);
          end
        end
        d = acc;
        good = date_in_range(d, m, y);
      end else if (k == cdadd_pkg::KIND_MONTHS) begin
        t = (m0 - 1) + amt;
        if (t >= 0) begin
          adj = t / 12;
        end else begin
          adj = -((-t + 11) / 12);
        end
        m = t - adj * 12 + 1;
        y = y0 + adj;
        good = date_in_range(d, m, y);
      end else if (k == cdadd_pkg::KIND_YEARS) begin
        y = y0 + amt;
        good = date_in_range(d, m, y);
      end
      if (!good) begin
        d = d0;
        m = m0;
        y = y0;
      end
      wd = weekday_index(d, m, y);
    end
    r.d = 5'(d);
    r.m = 4'(m);
    r.y = 14'(y);
    r.ok = good;
    r.wd = 3'(wd);
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $display("%0t ns: result word with none expected, expected none, actual %0d-%0d-%0d",
                 $time, new_year, new_month, new_day);
        errors++;
      end else begin
        oldest_date = expected_dates.pop_front();
        check_field("new_day", oldest_date.d, new_day);
        check_field("new_month", oldest_date.m, new_month);
        check_field("new_year", oldest_date.y, new_year);
        check_field("ok", oldest_date.ok, ok);
        check_field("weekday", oldest_date.wd, weekday);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_start <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_LIGHT:   out_stall <= ($urandom_range(3, 0) == 0);
        STALL_PATTERN: begin
          pattern_count <= pattern_count + 1;
          out_stall <= (pattern_count % 8) < 3;
        end
        default:       out_stall <= ($urandom_range(3, 0) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("calendar_date_adder_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [1:0] k, input logic [4:0] d, input logic [3:0] m,
                           input logic [13:0] y, input logic signed [15:0] a);
    in_valid <= 1'b1;
    kind <= k;
    day <= d;
    month <= m;
    year <= y;
    amount <= a;
    do @(posedge clk); while (in_stall);
    expected_dates.push_back(shift_date(k, d, m, y, a));
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pick_word(output logic [1:0] k, output logic [4:0] d, output logic [3:0] m,
                           output logic [13:0] y, output logic signed [15:0] a);
    int sel, yy, mm, tmp;
    if ($urandom_range(9, 0) < 8) begin
      sel = $urandom_range(9, 0);
      if (sel < 6) begin
        yy = $urandom_range(2150, cdadd_pkg::MIN_YEAR);
      end else if (sel < 8) begin
        yy = $urandom_range(cdadd_pkg::MAX_YEAR, cdadd_pkg::MIN_YEAR);
      end else begin
        yy = $urandom_range(cdadd_pkg::MAX_YEAR, cdadd_pkg::MAX_YEAR - 100);
      end
      mm = $urandom_range(12, 1);
      y = 14'(yy);
      m = 4'(mm);
      if ($urandom_range(7, 0) == 0) begin
        d = 5'd31;
      end else begin
        d = 5'($urandom_range(month_days(mm, yy), 1));
      end
      k = 2'($urandom_range(2, 0));
      sel = $urandom_range(19, 0);
      if (sel < 10) begin
        tmp = int'($urandom_range(800, 0)) - 400;
      end else if (sel < 15) begin
        tmp = int'($urandom_range(10000, 0)) - 5000;
      end else if (sel < 18) begin
        tmp = int'($urandom_range(65535, 0));
      end else begin
        case ($urandom_range(4, 0))
          0:       tmp = 0;
          1:       tmp = 1;
          2:       tmp = -1;
          3:       tmp = 32767;
          default: tmp = -32768;
        endcase
      end
      a = 16'(tmp);
    end else begin
      k = 2'($urandom);
      d = 5'($urandom);
      m = 4'($urandom);
      y = 14'($urandom);
      a = 16'($urandom);
    end
  endtask

  task automatic send_batch(input int count, input int max_gap);
    logic [1:0] k;
    logic [4:0] d;
    logic [3:0] m;
    logic [13:0] y;
    logic signed [15:0] a;
    int burst_left;
    burst_left = $urandom_range(8, 1);
    for (int i = 0; i < count; i++) begin
      pick_word(k, d, m, y, a);
      send_word(k, d, m, y, a);
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(8, 1);
        if (max_gap > 0) begin
          idle_gap($urandom_range(max_gap, 0));
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_dates();
    stall_mode <= STALL_LIGHT;
    send_word(cdadd_pkg::KIND_DAYS,   5'd29, 4'd2,  14'd2024, 16'sd0);
    send_word(cdadd_pkg::KIND_DAYS,   5'd28, 4'd2,  14'd2024, 16'sd1);
    send_word(cdadd_pkg::KIND_DAYS,   5'd28, 4'd2,  14'd1900, 16'sd1);
    send_word(cdadd_pkg::KIND_DAYS,   5'd28, 4'd2,  14'd2000, 16'sd1);
    send_word(cdadd_pkg::KIND_DAYS,   5'd1,  4'd1,  14'd1900, 16'sh7fff);
    send_word(cdadd_pkg::KIND_DAYS,   5'd31, 4'd12, 14'd9999, 16'sh8000);
    send_word(cdadd_pkg::KIND_DAYS,   5'd1,  4'd1,  14'd1900, -16'sd1);
    send_word(cdadd_pkg::KIND_DAYS,   5'd31, 4'd12, 14'd9999, 16'sd1);
    send_word(cdadd_pkg::KIND_DAYS,   5'd1,  4'd3,  14'd2000, -16'sd1);
    send_word(cdadd_pkg::KIND_MONTHS, 5'd31, 4'd1,  14'd2023, 16'sd1);
    send_word(cdadd_pkg::KIND_MONTHS, 5'd15, 4'd6,  14'd2000, 16'sh7fff);
    send_word(cdadd_pkg::KIND_MONTHS, 5'd15, 4'd6,  14'd2000, 16'sh8000);
    send_word(cdadd_pkg::KIND_MONTHS, 5'd15, 4'd1,  14'd2001, -16'sd13);
    send_word(cdadd_pkg::KIND_MONTHS, 5'd1,  4'd12, 14'd1999, 16'sd12);
    send_word(cdadd_pkg::KIND_YEARS,  5'd29, 4'd2,  14'd2024, 16'sd1);
    send_word(cdadd_pkg::KIND_YEARS,  5'd29, 4'd2,  14'd2024, 16'sd4);
    send_word(cdadd_pkg::KIND_YEARS,  5'd1,  4'd1,  14'd2000, 16'sh8000);
    send_word(cdadd_pkg::KIND_YEARS,  5'd1,  4'd1,  14'd1900, 16'sh7fff);
    send_word(cdadd_pkg::KIND_YEARS,  5'd1,  4'd3,  14'd2000, 16'sd7999);
    send_word(cdadd_pkg::KIND_DAYS,   5'd31, 4'd12, 14'd0,    16'sd5);
    send_word(KIND_UNUSED,            5'd31, 4'd15, 14'd16383, 16'sh7fff);
    send_word(cdadd_pkg::KIND_MONTHS, 5'd0,  4'd1,  14'd2000, 16'sd1);
    send_word(cdadd_pkg::KIND_YEARS,  5'd31, 4'd4,  14'd2010, 16'sd0);
    send_word(cdadd_pkg::KIND_DAYS,   5'd10, 4'd0,  14'd2010, 16'sd3);
    send_word(KIND_UNUSED,            5'd4,  4'd7,  14'd2021, 16'sd2);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    stall_mode <= STALL_NONE;
    send_batch(120, 0);
  endtask

  task automatic test_bursts_light_stall();
    stall_mode <= STALL_LIGHT;
    send_batch(120, 12);
  endtask

  task automatic test_output_hold();
    stall_mode <= STALL_NONE;
    hold_start <= 1'b1;
    send_batch(30, 0);
  endtask

  task automatic test_pause_until_drained();
    stall_mode <= STALL_PATTERN;
    send_batch(15, 4);
    wait_drained();
    send_batch(15, 4);
  endtask

  task automatic test_heavy_stall();
    stall_mode <= STALL_PATTERN;
    send_batch(60, 6);
    stall_mode <= STALL_HEAVY;
    send_batch(70, 6);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_dates();
    test_back_to_back();
    test_bursts_light_stall();
    test_output_hold();
    test_pause_until_drained();
    test_heavy_stall();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("calendar_date_adder_tb: done, clean");
    end else begin
      $display("calendar_date_adder_tb: done, errors");
    end
    $finish;
  end

endmodule
